// File: rtl/lkv_pkg.sv
// Shared constants for the LRU key-value cache.
package lkv_pkg;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

    localparam int             CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int RESULT_W = 32;

endpackage

// File: rtl/lkv_if.sv
// Request and response channel interfaces of the LRU key-value cache.
interface lkv_req_if #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] put_value;

    modport source (output valid, output func, output lookup_key, output put_value,
                    input ready);
    modport sink   (input valid, input func, input lookup_key, input put_value,
                    output ready);
endinterface

interface lkv_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [lkv_pkg::RESULT_W-1:0]  read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// File: rtl/lkv_apb_regs.sv
// APB register file holding the capacity register.
module lkv_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lkv_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lkv_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [lkv_pkg::CAP_W-1:0]         capacity
);
    import lkv_pkg::*;

    logic [CAP_W-1:0]     capacity_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (wr_en)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_CAPACITY)
        begin
            prdata = APB_DATA_W'(capacity_reg);
        end
    end

    assign capacity = capacity_reg;

endmodule

// File: rtl/lkv_cell.sv
// One cache cell: holds an entry, compares its key, takes its neighbor's entry on shift.
module lkv_cell #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift,
    input  logic                  prev_valid,
    input  logic [KEY_BITS-1:0]   prev_key,
    input  logic [VALUE_BITS-1:0] prev_value,
    input  logic [KEY_BITS-1:0]   lookup_key,
    output logic                  match,
    output logic                  entry_valid,
    output logic [KEY_BITS-1:0]   entry_key,
    output logic [VALUE_BITS-1:0] entry_value
);
    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    assign match       = valid_reg && (key_reg == lookup_key);
    assign entry_valid = valid_reg;
    assign entry_key   = key_reg;
    assign entry_value = value_reg;

endmodule

// File: rtl/lru_key_value_cache_unit.sv
// Top level of the LRU key-value cache: a recency-ordered row of cells.
//
//  channel | dir | handshake        | payload
//  req     | in  | valid / ready    | func, lookup_key, put_value
//  rsp     | out | valid / ready    | hit, read_value (one per get)
//  apb     | in  | psel/penable     | paddr, pwdata -> capacity
//
// One item per cycle while req is not stalled: key compare, shift of the cell row and
// the result register update all happen in the same cycle. Cell 0 holds the most recent entry.
// Reset clears all valid bits and the fill count; capacity returns to 16.
// A pending result stalls the request channel only while rsp is not ready.
module lru_key_value_cache_unit #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lkv_req_if.sink                           req,
    lkv_rsp_if.source                         rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lkv_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lkv_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import lkv_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [CAP_W-1:0]      capacity;
    logic [CNT_W-1:0]      limit;
    logic [8:0]            cap_wide;

    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [RESULT_W-1:0]   value_reg;
    logic [RESULT_W-1:0]   value_next;

    logic                  accept;
    logic                  is_put;
    logic                  any_hit;
    logic                  fill;
    logic [VALUE_BITS-1:0] hit_value;
    logic [VALUE_BITS-1:0] new_value;
    logic [63:0]           hit_value_wide;

    logic [ENTRIES-1:0]    match_vec;
    logic [ENTRIES-1:0]    hit_from;
    logic [ENTRIES-1:0]    shift_vec;
    logic [ENTRIES-1:0]    valid_vec;
    logic [KEY_BITS-1:0]   key_row   [ENTRIES];
    logic [VALUE_BITS-1:0] value_row [ENTRIES];

    lkv_apb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    assign cap_wide = 9'(capacity);

    always_comb
    begin
        if (capacity == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (cap_wide > 9'(ENTRIES))
        begin
            limit = CNT_W'(ENTRIES);
        end
        else
        begin
            limit = CNT_W'(capacity);
        end
    end

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_put    = (req.func == FUNC_PUT);
    assign any_hit   = |match_vec;
    assign fill      = cnt_reg < limit;

    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_value = hit_value | (value_row[i] & {VALUE_BITS{match_vec[i]}});
            hit_from[i] = |(match_vec & ({ENTRIES{1'b1}} << i));
        end
    end

    assign new_value      = is_put ? req.put_value : hit_value;
    assign hit_value_wide = 64'(hit_value);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!accept)
            begin
                shift_vec[i] = 1'b0;
            end
            else if (any_hit)
            begin
                shift_vec[i] = hit_from[i];
            end
            else if (is_put)
            begin
                shift_vec[i] = (cnt_reg > CNT_W'(i)) || (fill && (cnt_reg == CNT_W'(i)));
            end
            else
            begin
                shift_vec[i] = 1'b0;
            end
        end
    end

    generate
        for (genvar g = 0; g < ENTRIES; g++)
        begin : g_cell
            logic                  prev_valid;
            logic [KEY_BITS-1:0]   prev_key;
            logic [VALUE_BITS-1:0] prev_value;

            if (g == 0)
            begin : g_head
                assign prev_valid = 1'b1;
                assign prev_key   = req.lookup_key;
                assign prev_value = new_value;
            end
            else
            begin : g_body
                assign prev_valid = valid_vec[g-1];
                assign prev_key   = key_row[g-1];
                assign prev_value = value_row[g-1];
            end

            lkv_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift       (shift_vec[g]),
                .prev_valid  (prev_valid),
                .prev_key    (prev_key),
                .prev_value  (prev_value),
                .lookup_key  (req.lookup_key),
                .match       (match_vec[g]),
                .entry_valid (valid_vec[g]),
                .entry_key   (key_row[g]),
                .entry_value (value_row[g])
            );
        end
    endgenerate

    always_comb
    begin
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        hit_next       = hit_reg;
        value_next     = value_reg;
        if (accept && is_put && !any_hit && fill)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (accept && !is_put)
        begin
            rsp_valid_next = 1'b1;
            hit_next       = any_hit;
            value_next     = any_hit ? hit_value_wide[RESULT_W-1:0] : '0;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        value_reg <= value_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hit        = hit_reg;
    assign rsp.read_value = value_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ENTRIES))
        else $error("fill count above entry count");

    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(cnt_reg))
        else $error("valid cells disagree with fill count");

    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("key stored in more than one cell");

    a_put_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_put && rsp.ready |=> !rsp.valid)
        else $error("put produced a result");

endmodule
